/* src/tcsf_pkg.sv */
// Package for the touch contact slot framer.
// Holds the item, frame and table entry types, the state and phase codes
// and the frame byte constants. No dependencies.
package tcsf_pkg;

    // Stored slot number width and frame geometry
    localparam int SLOT_W    = 5;
    localparam int PHASE_W   = 2;
    localparam int FRAME_LEN = 14;
    localparam int CNT_W     = 4;
    localparam int CFG_AW    = 3;

    // Frame marker bytes
    localparam logic [7:0] FRAME_SOF = 8'hF3;
    localparam logic [7:0] FRAME_LEN_BYTE = 8'h0E;
    localparam logic [7:0] FRAME_EOF = 8'hF4;

    // Contact state nibble codes
    localparam logic [3:0] ST_TOUCH = 4'd7;
    localparam logic [3:0] ST_LIFT  = 4'd4;

    // Configuration register indexes
    localparam logic [0:0] REG_BOARD_ACTIVE = 1'b0;

    // Contact phase codes
    typedef enum logic [PHASE_W-1:0] {
        PH_DOWN = 2'd0,
        PH_UP   = 2'd1,
        PH_MOVE = 2'd2
    } t_phase;

    // One input contact record
    typedef struct packed {
        logic        start_of_report;
        logic [7:0]  contact_id;
        logic [3:0]  contact_state;
        logic [3:0]  contact_type;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [15:0] size_w;
        logic [15:0] size_h;
    } t_item;

    // One entry of the contact table memory
    typedef struct packed {
        logic [SLOT_W-1:0]  slot;
        logic [PHASE_W-1:0] phase;
    } t_entry;

    // Fields of one frame to be serialized
    typedef struct packed {
        logic [3:0]         contact_type;
        logic [SLOT_W-1:0]  slot;
        logic [PHASE_W-1:0] phase;
        logic [15:0]        pos_x;
        logic [15:0]        pos_y;
        logic [15:0]        size_w;
        logic [15:0]        size_h;
    } t_frame;

endpackage

/* src/tcsf_if.sv */
// Channel interfaces of the touch contact slot framer: contact records in,
// frame bytes out. Depends on tcsf_pkg.
interface tcsf_item_if import tcsf_pkg::*; ();
    logic        valid;
    logic        ready;
    logic        start_of_report;
    logic [7:0]  contact_id;
    logic [3:0]  contact_state;
    logic [3:0]  contact_type;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] size_w;
    logic [15:0] size_h;

    modport source (
        output valid, start_of_report, contact_id, contact_state, contact_type,
               pos_x, pos_y, size_w, size_h,
        input  ready
    );
    modport sink (
        input  valid, start_of_report, contact_id, contact_state, contact_type,
               pos_x, pos_y, size_w, size_h,
        output ready
    );
endinterface

interface tcsf_frame_if ();
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       frame_last;

    modport source (output valid, frame_byte, frame_last, input ready);
    modport sink (input valid, frame_byte, frame_last, output ready);
endinterface

/* src/tcsf_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module tcsf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

/* src/tcsf_slot_ctl.sv */
// Slot tracker: reads the contact table, applies the touch/lift rules,
// writes back and hands finished frames to the serializer.
// Depends on tcsf_pkg, tcsf_if and tcsf_ram.
module tcsf_slot_ctl import tcsf_pkg::*; #(
    parameter int CONTACT_IDS = 64,
    parameter int SLOT_COUNT  = 20
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_board_active,
    tcsf_item_if.sink   i_item,
    output t_frame      o_frame,
    output logic        o_frame_load,
    input  logic        i_frame_free
);

    localparam int AW = (CONTACT_IDS > 1) ? $clog2(CONTACT_IDS) : 1;

    // Lookup stage
    logic             r_s1_valid;
    t_item            r_s1_item;
    // Flop state
    logic [CONTACT_IDS-1:0] r_assigned;
    logic [SLOT_COUNT-1:0]  r_busy;
    logic                   r_skip;
    // Forwarding of the last write-back
    logic             r_fwd_valid;
    logic [AW-1:0]    r_fwd_id;
    t_entry           r_fwd_data;

    logic             w_hold;
    logic             w_done;
    logic [AW-1:0]    w_raddr;
    logic [AW-1:0]    w_idx;
    t_entry           w_rdata;
    t_entry           w_entry;
    t_entry           n_entry;
    logic             w_we;
    logic             w_in_range;
    logic             w_skip_eff;
    logic             w_end_mark;
    logic             w_proc;
    logic             w_asg_cur;
    logic             w_asg_new;
    logic             w_emit;
    logic             w_alloc;
    logic             w_release;
    logic             w_free_found;
    logic [SLOT_W-1:0] w_free_slot;
    logic             n_skip;
    t_item            w_in;

    assign w_in = '{
        start_of_report: i_item.start_of_report,
        contact_id:      i_item.contact_id,
        contact_state:   i_item.contact_state,
        contact_type:    i_item.contact_type,
        pos_x:           i_item.pos_x,
        pos_y:           i_item.pos_y,
        size_w:          i_item.size_w,
        size_h:          i_item.size_h
    };

    // Re-read the held entry while stalled, else look up the incoming item
    assign w_raddr = w_hold ? r_s1_item.contact_id[AW-1:0] : i_item.contact_id[AW-1:0];
    assign w_idx   = r_s1_item.contact_id[AW-1:0];

    tcsf_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (CONTACT_IDS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_idx),
        .i_wdata (n_entry),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Lowest free slot
    always_comb begin
        w_free_found = 1'b0;
        w_free_slot  = '0;
        for (int s = SLOT_COUNT - 1; s >= 0; s--) begin
            if (!r_busy[s]) begin
                w_free_found = 1'b1;
                w_free_slot  = SLOT_W'(s);
            end
        end
    end

    // Record classification and table update
    always_comb begin
        w_entry    = (r_fwd_valid && r_fwd_id == w_idx) ? r_fwd_data : w_rdata;
        w_in_range = {1'b0, r_s1_item.contact_id} < 9'(CONTACT_IDS);
        w_skip_eff = r_s1_item.start_of_report ? 1'b0 : r_skip;
        w_end_mark = (r_s1_item.pos_x == 16'd0) && (r_s1_item.pos_y == 16'd0);
        w_proc     = i_board_active && !w_skip_eff && !w_end_mark && w_in_range;
        w_asg_cur  = w_in_range && r_assigned[w_idx];
        n_skip     = i_board_active ? (w_skip_eff || w_end_mark) : r_skip;

        n_entry   = w_entry;
        w_we      = 1'b0;
        w_alloc   = 1'b0;
        w_release = 1'b0;
        w_asg_new = w_asg_cur;
        if (w_proc) begin
            if (r_s1_item.contact_state == ST_TOUCH) begin
                if (!w_asg_cur) begin
                    if (w_free_found) begin
                        w_alloc       = 1'b1;
                        w_asg_new     = 1'b1;
                        n_entry.slot  = w_free_slot;
                        n_entry.phase = PH_DOWN;
                        w_we          = 1'b1;
                    end
                end else if (w_entry.phase == PH_DOWN) begin
                    n_entry.phase = PH_MOVE;
                    w_we          = 1'b1;
                end
            end else if (r_s1_item.contact_state == ST_LIFT) begin
                if (w_asg_cur) begin
                    n_entry.phase = PH_UP;
                    w_release     = 1'b1;
                end
            end
        end
        w_emit = w_proc && w_asg_new;
    end

    // Stall the lookup stage only when a frame waits for the serializer
    assign w_hold         = r_s1_valid && w_emit && !i_frame_free;
    assign w_done         = r_s1_valid && !w_hold;
    assign i_item.ready   = !r_s1_valid || !w_hold;
    assign o_frame_load   = r_s1_valid && w_emit && i_frame_free;

    assign o_frame = '{
        contact_type: r_s1_item.contact_type,
        slot:         n_entry.slot,
        phase:        n_entry.phase,
        pos_x:        r_s1_item.pos_x,
        pos_y:        r_s1_item.pos_y,
        size_w:       r_s1_item.size_w,
        size_h:       r_s1_item.size_h
    };

    // Advance the lookup stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_s1_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.ready && i_item.valid) begin
            r_s1_item <= w_in;
        end
    end

    // Commit assignment, slot and skip state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_assigned <= '0;
            r_busy     <= '0;
            r_skip     <= 1'b0;
        end else if (w_done) begin
            r_skip <= n_skip;
            if (w_alloc) begin
                r_assigned[w_idx] <= 1'b1;
            end
            if (w_release) begin
                r_assigned[w_idx] <= 1'b0;
            end
            for (int s = 0; s < SLOT_COUNT; s++) begin
                if (w_alloc && w_free_slot == SLOT_W'(s)) begin
                    r_busy[s] <= 1'b1;
                end
                if (w_release && w_entry.slot == SLOT_W'(s)) begin
                    r_busy[s] <= 1'b0;
                end
            end
        end
    end

    // Remember the last write-back for a lookup that raced it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_valid <= 1'b0;
        end else begin
            r_fwd_valid <= w_we && w_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_id   <= w_idx;
        r_fwd_data <= n_entry;
    end

endmodule

/* src/tcsf_frame_ser.sv */
// Frame serializer: holds one frame and sends its 14 bytes one per item.
// Depends on tcsf_pkg and tcsf_if.
module tcsf_frame_ser import tcsf_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_frame       i_frame,
    input  logic         i_load,
    output logic         o_free,
    tcsf_frame_if.source o_frame
);

    localparam logic [CNT_W-1:0] LAST_POS = CNT_W'(FRAME_LEN - 1);

    logic             r_valid;
    logic [CNT_W-1:0] r_cnt;
    t_frame           r_frame;
    logic [7:0]       w_bytes [FRAME_LEN];
    logic             w_take;

    assign w_take = r_valid && o_frame.ready;
    assign o_free = !r_valid || (w_take && r_cnt == LAST_POS);

    // Frame layout
    always_comb begin
        w_bytes[0]  = FRAME_SOF;
        w_bytes[1]  = FRAME_LEN_BYTE;
        w_bytes[2]  = {4'b0, r_frame.contact_type};
        w_bytes[3]  = 8'(r_frame.slot) + 8'd1;
        w_bytes[4]  = {6'b0, r_frame.phase};
        w_bytes[5]  = r_frame.pos_x[15:8];
        w_bytes[6]  = r_frame.pos_x[7:0];
        w_bytes[7]  = r_frame.pos_y[15:8];
        w_bytes[8]  = r_frame.pos_y[7:0];
        w_bytes[9]  = r_frame.size_w[15:8];
        w_bytes[10] = r_frame.size_w[7:0];
        w_bytes[11] = r_frame.size_h[15:8];
        w_bytes[12] = r_frame.size_h[7:0];
        w_bytes[13] = FRAME_EOF;
    end

    assign o_frame.valid      = r_valid;
    assign o_frame.frame_byte = w_bytes[r_cnt];
    assign o_frame.frame_last = (r_cnt == LAST_POS);

    // Load a new frame or advance the byte pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_cnt   <= '0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_cnt   <= '0;
        end else if (w_take) begin
            if (r_cnt == LAST_POS) begin
                r_valid <= 1'b0;
            end else begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_frame <= i_frame;
        end
    end

endmodule

/* src/touch_contact_slot_framer_top.sv */
// Top level of the touch contact slot framer: configuration register,
// slot tracker and frame serializer. Depends on tcsf_pkg, tcsf_if,
// tcsf_slot_ctl and tcsf_frame_ser.
//
// Usage: contact records enter on i_item (valid/ready), one per item.
// Each processed record whose id holds or gets a slot produces a
// 14-byte frame on o_frame, one byte per item, frame_last marking the
// closing F4 byte. Records that produce no frame are taken at one per
// cycle while no frame waits in the lookup stage. The table read lands
// on the accepting edge, and the frame register loads once the
// serializer is free; its first byte is then valid. The next record is
// accepted while a frame is being sent, and a second frame waits in the
// lookup stage until the last byte goes out. Framed records are thus
// limited by the output, which sends one byte per cycle while the
// receiver is ready. The board_active register (paddr[2] low on the APB
// port) drops every record while zero. At reset all ids are unassigned,
// all slots free, the skip flag is clear and board_active is zero. When
// the receiver stalls, the current byte holds and the input stops once
// a frame waits in the lookup stage.
module touch_contact_slot_framer_top import tcsf_pkg::*; #(
    parameter int CONTACT_IDS = 64,
    parameter int SLOT_COUNT  = 20
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    tcsf_item_if.sink         i_item,
    tcsf_frame_if.source      o_frame,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic   r_board_active;
    t_frame w_frame;
    logic   w_load;
    logic   w_free;

    // Configuration register
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_board_active <= 1'b0;
        end else if (psel && penable && pwrite && paddr[2] == REG_BOARD_ACTIVE) begin
            r_board_active <= pwdata[0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_BOARD_ACTIVE) begin
            prdata = {31'b0, r_board_active};
        end
    end

    tcsf_slot_ctl #(
        .CONTACT_IDS (CONTACT_IDS),
        .SLOT_COUNT  (SLOT_COUNT)
    ) u_slot_ctl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_board_active (r_board_active),
        .i_item         (i_item),
        .o_frame        (w_frame),
        .o_frame_load   (w_load),
        .i_frame_free   (w_free)
    );

    tcsf_frame_ser u_frame_ser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_frame (w_frame),
        .i_load  (w_load),
        .o_free  (w_free),
        .o_frame (o_frame)
    );

    // Closing byte is always the end marker
    a_last_is_eof: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_frame.valid && o_frame.frame_last |-> o_frame.frame_byte == FRAME_EOF)
        else $error("frame_last on a byte other than the end marker");

    // A byte right after a frame's last byte, if valid, is the start marker
    a_next_is_sof: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_frame.valid && o_frame.ready && o_frame.frame_last
        |=> !o_frame.valid || o_frame.frame_byte == FRAME_SOF)
        else $error("frame does not open with the start marker");

    // Bytes of one frame follow without gaps
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_frame.valid && o_frame.ready && !o_frame.frame_last |=> o_frame.valid)
        else $error("gap inside a frame");

endmodule
